// ----- rtl/fde_pkg.sv -----
package fde_pkg;

    localparam int NUM_DIGITS = 8;
    localparam int GRID_BYTES = 4 * NUM_DIGITS;
    localparam int SHOW_LEN   = GRID_BYTES + 2;
    localparam int INIT_LEN   = 19;
    localparam int IDX_W      = $clog2((SHOW_LEN > INIT_LEN) ? SHOW_LEN : INIT_LEN);
    localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    localparam logic [7:0] CMD_DATA_WRITE  = 8'h40;
    localparam logic [7:0] CMD_SHOW_ON     = 8'h8A;
    localparam logic [7:0] CMD_BRIGHT_BASE = 8'h88;
    localparam logic [7:0] CMD_BRIGHT_MAX  = 8'h8F;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h8B;
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h80;
    localparam logic [7:0] CMD_INIT_CTRL   = 8'h87;
    localparam logic [7:0] ADDR_BASE       = 8'hC0;
    localparam logic [7:0] FILL_BYTE       = 8'h00;

    typedef enum logic [1:0] {
        REQ_SHOW   = 2'd0,
        REQ_BRIGHT = 2'd1,
        REQ_POWER  = 2'd2,
        REQ_INIT   = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t   req_type;
        logic [3:0]  digit_0;
        logic [3:0]  digit_1;
        logic [3:0]  digit_2;
        logic [3:0]  digit_3;
        logic [3:0]  digit_4;
        logic [3:0]  digit_5;
        logic [3:0]  digit_6;
        logic [3:0]  digit_7;
        logic [7:0]  dot_mask;
        logic [7:0]  bright_level;
        logic        display_on;
    } req_t;

    typedef struct packed {
        logic [7:0] bus_byte;
        logic       frame_start;
        logic       frame_end;
        logic       run_last;
    } frame_t;

    typedef struct packed {
        logic [3:0] hi;
        logic [3:0] lo;
    } nibble_t;

    function automatic logic [7:0] seg_lookup(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hFC;
            4'd1:    s = 8'h60;
            4'd2:    s = 8'hDA;
            4'd3:    s = 8'hF2;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'hB6;
            4'd6:    s = 8'hBE;
            4'd7:    s = 8'hE0;
            4'd8:    s = 8'hFE;
            4'd9:    s = 8'hF6;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] req_digit(input req_t r, input int p);
        logic [3:0] d;
        case (p)
            0:       d = r.digit_0;
            1:       d = r.digit_1;
            2:       d = r.digit_2;
            3:       d = r.digit_3;
            4:       d = r.digit_4;
            5:       d = r.digit_5;
            6:       d = r.digit_6;
            default: d = r.digit_7;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/led_digit_display_frame_encoder.sv -----
// The request is captured in the sequencer registers; its first byte is then loaded into
// the output register once that register is free.
// Throughput: one byte per cycle from the byte sequencer while frame_ready is held; a show
// request is 4*NUM_DIGITS+2 bytes (34), an init request 19 bytes, brightness or on/off 1.
// The next request is taken in the cycle the previous one issues its last byte.
// Reset (rst_n, async, active low) clears the sequencer and output valid.
module led_digit_display_frame_encoder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  fde_pkg::req_t   req_data,
    output logic            frame_valid,
    input  logic            frame_ready,
    output fde_pkg::frame_t frame_data
);

    fde_pkg::nibble_t lane_nib [fde_pkg::NUM_DIGITS];

    for (genvar p = 0; p < fde_pkg::NUM_DIGITS; p++)
    begin : g_lane
        fde_lane u_lane (
            .digit (fde_pkg::req_digit(req_data, p)),
            .dot   (req_data.dot_mask[p]),
            .nib   (lane_nib[p])
        );
    end

    fde_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .lane_nib    (lane_nib),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_data  (frame_data)
    );

    a_stall_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready && !frame_data.run_last |-> !req_ready)
        else $error("request taken while a run is stalled mid-stream");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_data.run_last |-> frame_data.frame_end)
        else $error("last byte of a run does not close its frame");

    a_req_yields_byte: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> ##1 frame_valid)
        else $error("no byte presented after a request transfer");

endmodule

// ----- rtl/fde_lane.sv -----
module fde_lane (
    input  logic [3:0]      digit,
    input  logic            dot,
    output fde_pkg::nibble_t nib
);

    logic [7:0] seg;

    assign seg    = fde_pkg::seg_lookup(digit);
    assign nib.lo = {seg[4], seg[5], seg[6], seg[7]};
    assign nib.hi = {seg[0] | dot, seg[1], seg[2], seg[3]};

endmodule

// ----- rtl/fde_seq.sv -----
module fde_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  fde_pkg::req_t     req_data,
    input  fde_pkg::nibble_t  lane_nib [fde_pkg::NUM_DIGITS],
    output logic              frame_valid,
    input  logic              frame_ready,
    output fde_pkg::frame_t   frame_data
);

    logic                      busy_reg, busy_next;
    logic [fde_pkg::IDX_W-1:0] idx_reg, idx_next;
    fde_pkg::req_kind_t        type_reg;
    logic [7:0]                cmd_reg;
    logic [3:0]                lo_reg [fde_pkg::NUM_DIGITS];
    logic [3:0]                hi_reg [fde_pkg::NUM_DIGITS];
    logic                      out_valid_reg, out_valid_next;
    fde_pkg::frame_t           out_reg;

    logic                      load;
    logic                      accept;
    fde_pkg::frame_t           cur;
    logic [fde_pkg::DIG_W-1:0] gsel;
    logic [1:0]                sub;
    logic [7:0]                cmd_in;

    assign gsel = idx_reg[fde_pkg::DIG_W+1:2];
    assign sub  = idx_reg[1:0];

    always_comb
    begin
        cur = '0;
        case (type_reg)
            fde_pkg::REQ_SHOW:
            begin
                if (idx_reg < fde_pkg::IDX_W'(fde_pkg::GRID_BYTES))
                begin
                    case (sub)
                        2'd0:
                        begin
                            cur.bus_byte    = fde_pkg::ADDR_BASE + 8'({gsel, 1'b0});
                            cur.frame_start = 1'b1;
                        end
                        2'd1:
                        begin
                            cur.bus_byte  = {4'b0000, lo_reg[gsel]};
                            cur.frame_end = 1'b1;
                        end
                        2'd2:
                        begin
                            cur.bus_byte    = fde_pkg::ADDR_BASE + 8'({gsel, 1'b1});
                            cur.frame_start = 1'b1;
                        end
                        default:
                        begin
                            cur.bus_byte  = {4'b0000, hi_reg[gsel]};
                            cur.frame_end = 1'b1;
                        end
                    endcase
                end
                else if (idx_reg == fde_pkg::IDX_W'(fde_pkg::GRID_BYTES))
                begin
                    cur.bus_byte    = fde_pkg::CMD_DATA_WRITE;
                    cur.frame_start = 1'b1;
                    cur.frame_end   = 1'b1;
                end
                else
                begin
                    cur.bus_byte    = fde_pkg::CMD_SHOW_ON;
                    cur.frame_start = 1'b1;
                    cur.frame_end   = 1'b1;
                    cur.run_last    = 1'b1;
                end
            end
            fde_pkg::REQ_BRIGHT,
            fde_pkg::REQ_POWER:
            begin
                cur.bus_byte    = cmd_reg;
                cur.frame_start = 1'b1;
                cur.frame_end   = 1'b1;
                cur.run_last    = 1'b1;
            end
            fde_pkg::REQ_INIT:
            begin
                if (idx_reg == fde_pkg::IDX_W'(0))
                begin
                    cur.bus_byte    = fde_pkg::CMD_DATA_WRITE;
                    cur.frame_start = 1'b1;
                    cur.frame_end   = 1'b1;
                end
                else if (idx_reg == fde_pkg::IDX_W'(1))
                begin
                    cur.bus_byte    = fde_pkg::CMD_INIT_CTRL;
                    cur.frame_start = 1'b1;
                    cur.frame_end   = 1'b1;
                end
                else
                begin
                    cur.bus_byte    = fde_pkg::FILL_BYTE;
                    cur.frame_start = (idx_reg == fde_pkg::IDX_W'(2));
                    cur.frame_end   = (idx_reg == fde_pkg::IDX_W'(fde_pkg::INIT_LEN - 1));
                    cur.run_last    = cur.frame_end;
                end
            end
            default:
            begin
                cur = '0;
            end
        endcase
    end

    always_comb
    begin
        if (req_data.req_type == fde_pkg::REQ_BRIGHT)
        begin
            if (req_data.bright_level == 8'd0)
                cmd_in = fde_pkg::CMD_BRIGHT_BASE;
            else if (req_data.bright_level > 8'd8)
                cmd_in = fde_pkg::CMD_BRIGHT_MAX;
            else
                cmd_in = fde_pkg::CMD_BRIGHT_BASE + req_data.bright_level - 8'd1;
        end
        else
        begin
            cmd_in = req_data.display_on ? fde_pkg::CMD_DISPLAY_ON : fde_pkg::CMD_DISPLAY_OFF;
        end
    end

    assign load      = busy_reg && (!out_valid_reg || frame_ready);
    assign req_ready = !busy_reg || (load && cur.run_last);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + fde_pkg::IDX_W'(1);
            if (cur.run_last)
                busy_next = 1'b0;
        end
        else if (frame_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= cur;
        if (accept)
        begin
            type_reg <= req_data.req_type;
            cmd_reg  <= cmd_in;
            for (int p = 0; p < fde_pkg::NUM_DIGITS; p++)
            begin
                lo_reg[p] <= lane_nib[p].lo;
                hi_reg[p] <= lane_nib[p].hi;
            end
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame_data  = out_reg;

endmodule

// ----- tb/sv/frame_stream_scoreboard.sv -----
module frame_stream_scoreboard
    import fde_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    input  logic   req_ready,
    input  req_t   req_data,
    input  logic   frame_valid,
    input  logic   frame_ready,
    input  frame_t frame_data,
    output int     mismatches,
    output int     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // bit 7 is segment a, bit 1 is segment g; codes 10..15 are blank
    localparam logic [7:0] SEGMENTS [16] = '{
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
        8'hFE, 8'hF6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    frame_t expected_bytes [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic frame_t make_byte(input logic [7:0] b, input logic s, input logic e);
        frame_t f;
        f.bus_byte    = b;
        f.frame_start = s;
        f.frame_end   = e;
        f.run_last    = 1'b0;
        return f;
    endfunction

    task automatic encode_request(input req_t r);
        logic [31:0] digits;
        logic [7:0]  seg;
        logic [7:0]  level;
        logic [3:0]  lo;
        logic [3:0]  hi;
        frame_t      last;
        digits = {r.digit_7, r.digit_6, r.digit_5, r.digit_4,
                  r.digit_3, r.digit_2, r.digit_1, r.digit_0};
        case (r.req_type)
            REQ_SHOW:
            begin
                for (int p = 0; p < NUM_DIGITS; p++)
                begin
                    seg = SEGMENTS[digits[4*p +: 4]];
                    for (int k = 0; k < 4; k++)
                    begin
                        lo[k] = seg[7-k];
                        hi[k] = seg[3-k];
                    end
                    hi[3] = hi[3] | r.dot_mask[p];
                    expected_bytes.push_back(make_byte(ADDR_BASE + 8'(2*p), 1'b1, 1'b0));
                    expected_bytes.push_back(make_byte({4'h0, lo}, 1'b0, 1'b1));
                    expected_bytes.push_back(make_byte(ADDR_BASE + 8'(2*p+1), 1'b1, 1'b0));
                    expected_bytes.push_back(make_byte({4'h0, hi}, 1'b0, 1'b1));
                end
                expected_bytes.push_back(make_byte(CMD_DATA_WRITE, 1'b1, 1'b1));
                expected_bytes.push_back(make_byte(CMD_SHOW_ON, 1'b1, 1'b1));
            end
            REQ_BRIGHT:
            begin
                level = r.bright_level;
                if (level == 8'd0)
                    level = 8'd1;
                else if (level > 8'd8)
                    level = 8'd8;
                expected_bytes.push_back(make_byte(CMD_BRIGHT_BASE + level - 8'd1, 1'b1, 1'b1));
            end
            REQ_POWER:
            begin
                expected_bytes.push_back(make_byte(r.display_on ? CMD_DISPLAY_ON : CMD_DISPLAY_OFF,
                                                   1'b1, 1'b1));
            end
            default:
            begin
                expected_bytes.push_back(make_byte(CMD_DATA_WRITE, 1'b1, 1'b1));
                expected_bytes.push_back(make_byte(CMD_INIT_CTRL, 1'b1, 1'b1));
                for (int k = 0; k < 17; k++)
                    expected_bytes.push_back(make_byte(FILL_BYTE, k == 0, k == 16));
            end
        endcase
        // mark the final byte of this request
        last = expected_bytes.pop_back();
        last.run_last = 1'b1;
        expected_bytes.push_back(last);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n)
        begin
            if (frame_valid && frame_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("bus_byte: expected none, got %0h", frame_data.bus_byte);
                    mismatches++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    check_field("bus_byte", want.bus_byte, frame_data.bus_byte);
                    check_field("frame_start", 8'(want.frame_start), 8'(frame_data.frame_start));
                    check_field("frame_end", 8'(want.frame_end), 8'(frame_data.frame_end));
                    check_field("run_last", 8'(want.run_last), 8'(frame_data.run_last));
                end
            end
            if (req_valid && req_ready)
                encode_request(req_data);
            outstanding = expected_bytes.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fde_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   req_valid;
    logic   req_ready;
    req_t   req_data;
    logic   frame_valid;
    logic   frame_ready;
    frame_t frame_data;

    int mismatches;
    int outstanding;
    int gap_max     = 15;
    int stall_max   = 15;
    bit hold_output = 1'b0;
    int quiet_cycles = 0;

    always #4 clk = ~clk;

    led_digit_display_frame_encoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_data  (frame_data)
    );

    frame_stream_scoreboard scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_data    (req_data),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_data  (frame_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            r.req_type = REQ_SHOW;
        else if (pick < 70)
            r.req_type = REQ_BRIGHT;
        else if (pick < 85)
            r.req_type = REQ_POWER;
        else
            r.req_type = REQ_INIT;
        {r.digit_7, r.digit_6, r.digit_5, r.digit_4,
         r.digit_3, r.digit_2, r.digit_1, r.digit_0} = $urandom;
        r.dot_mask     = 8'($urandom_range(0, 255));
        r.bright_level = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 9))
                                                     : 8'($urandom_range(0, 255));
        r.display_on   = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic req_t show_request(input logic [31:0] digits, input logic [7:0] dots);
        req_t r;
        r = random_request();
        r.req_type = REQ_SHOW;
        {r.digit_7, r.digit_6, r.digit_5, r.digit_4,
         r.digit_3, r.digit_2, r.digit_1, r.digit_0} = digits;
        r.dot_mask = dots;
        return r;
    endfunction

    function automatic req_t control_request(input req_kind_t kind, input logic [7:0] level,
                                             input logic on);
        req_t r;
        r = random_request();
        r.req_type     = kind;
        r.bright_level = level;
        r.display_on   = on;
        return r;
    endfunction

    task automatic send_request(input req_t r);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic run_random(input int count, input int gaps, input int stalls);
        gap_max   = gaps;
        stall_max = stalls;
        repeat (count) send_request(random_request());
    endtask

    // receiver: random back-pressure, with one long hold-off on request
    initial
    begin
        int stall;
        frame_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                stall = HOLD_CYCLES;
                hold_output = 1'b0;
            end
            else
                stall = $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                frame_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            frame_ready <= 1'b1;
            do @(posedge clk); while (!frame_valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (frame_valid && frame_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(control_request(REQ_INIT, 8'hFF, 1'b1));
        send_request(show_request(32'h7654_3210, 8'h00));
        send_request(show_request(32'hFEDC_BA98, 8'hFF));
        send_request(show_request(32'hFFFF_FFFF, 8'hA5));
        send_request(show_request(32'h0000_0000, 8'h5A));
        send_request(show_request(32'h8888_8888, 8'h01));
        for (int lv = 0; lv <= 9; lv++)
            send_request(control_request(REQ_BRIGHT, 8'(lv), 1'b0));
        send_request(control_request(REQ_BRIGHT, 8'h80, 1'b1));
        send_request(control_request(REQ_BRIGHT, 8'hFF, 1'b0));
        send_request(control_request(REQ_POWER, 8'h00, 1'b1));
        send_request(control_request(REQ_POWER, 8'hFF, 1'b0));
        send_request(control_request(REQ_INIT, 8'h00, 1'b0));
        drain();

        run_random(120, 15, 15);
        run_random(110, 0, 0);
        hold_output = 1'b1;
        run_random(110, 0, 15);
        drain();
        run_random(120, 15, 0);

        stall_max = 0;
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
